// ===== design/ppsc_pkg.sv =====
// Shared types, codes and constants of the polar pose steering controller.
package ppsc_pkg;

  localparam int POS_W = 16;
  localparam int DIFF_W = POS_W + 1;
  localparam int ANG_W = 16;
  localparam int CFG_W = 16;
  localparam int ROOT_STEPS = 17;
  localparam int ATAN_LEN = 24;
  localparam int JOBQ_DEPTH = 2;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q12 = 16'sd6434;

  localparam logic [1:0] OP_POSE = 2'd0;
  localparam logic [1:0] OP_TARGET = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] REG_STOP_TOL = 2'd0;
  localparam logic [1:0] REG_GAIN_DIST = 2'd1;
  localparam logic [1:0] REG_GAIN_ALPHA = 2'd2;
  localparam logic [1:0] REG_GAIN_BETA = 2'd3;

  localparam logic [CFG_W-1:0] STOP_TOL_RESET = 16'd26;
  localparam logic signed [CFG_W-1:0] GAIN_DIST_RESET = 16'sd256;
  localparam logic signed [CFG_W-1:0] GAIN_ALPHA_RESET = 16'sd2048;
  localparam logic signed [CFG_W-1:0] GAIN_BETA_RESET = -16'sd512;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic                     computed;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [ANG_W-1:0]  heading;
  } job_t;

  typedef struct packed {
    logic [CFG_W-1:0]        stop_tol;
    logic signed [CFG_W-1:0] gain_dist;
    logic signed [CFG_W-1:0] gain_alpha;
    logic signed [CFG_W-1:0] gain_beta;
  } cfg_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    val = '0;
    if (int'(idx) < ATAN_LEN) begin
      val = ATAN_TAB[idx];
    end
    return val;
  endfunction

endpackage

// ===== design/ppsc_front.sv =====
// Front end: accepts items, keeps the pose and target, and turns each tick into a job.
module ppsc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic [1:0]                      op,
  input  logic signed [ppsc_pkg::POS_W-1:0] pos_x,
  input  logic signed [ppsc_pkg::POS_W-1:0] pos_y,
  input  logic signed [ppsc_pkg::ANG_W-1:0] heading,
  output logic                            job_push,
  output ppsc_pkg::job_t                  job
);
  import ppsc_pkg::*;

  logic signed [POS_W-1:0] cur_x;
  logic signed [POS_W-1:0] cur_y;
  logic signed [ANG_W-1:0] cur_heading;
  logic signed [POS_W-1:0] tgt_x;
  logic signed [POS_W-1:0] tgt_y;
  logic                    pose_fresh;
  logic                    target_known;
  logic                    accept;
  logic                    ready_both;

  assign accept = push && !full;
  assign ready_both = pose_fresh && target_known;
  assign job_push = accept && (op == OP_TICK);

  always_comb begin
    job.computed = ready_both;
    job.dx = DIFF_W'(tgt_x) - DIFF_W'(cur_x);
    job.dy = DIFF_W'(tgt_y) - DIFF_W'(cur_y);
    job.heading = cur_heading;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_fresh <= 1'b0;
      target_known <= 1'b0;
      cur_x <= '0;
      cur_y <= '0;
      cur_heading <= '0;
      tgt_x <= '0;
      tgt_y <= '0;
    end else if (accept) begin
      case (op)
        OP_POSE: begin
          cur_x <= pos_x;
          cur_y <= pos_y;
          cur_heading <= heading;
          pose_fresh <= 1'b1;
        end
        OP_TARGET: begin
          tgt_x <= pos_x;
          tgt_y <= pos_y;
          target_known <= 1'b1;
        end
        OP_TICK: begin
          if (ready_both) begin
            pose_fresh <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/ppsc_jobq.sv =====
// Short job queue between the front end and the compute back end.
module ppsc_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  ppsc_pkg::job_t wr_job,
  input  logic           rd_en,
  output ppsc_pkg::job_t rd_job,
  output logic           q_full,
  output logic           q_empty
);
  import ppsc_pkg::*;

  localparam int PTR_W = $clog2(JOBQ_DEPTH);
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             slots [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full = (count == CNT_W'(JOBQ_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr = wr_en && !q_full;
  assign do_rd = rd_en && !q_empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/ppsc_back.sv =====
// Back end: distance, bearing and control law for each job, with a one-entry result register.
module ppsc_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ppsc_pkg::cfg_t                    cfg,
  input  ppsc_pkg::job_t                    job,
  input  logic                              q_empty,
  output logic                              job_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [ppsc_pkg::POS_W-1:0] velocity,
  output logic signed [ppsc_pkg::ANG_W-1:0] steering,
  output logic                              computed,
  output logic                              reversed
);
  import ppsc_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
  localparam int RCNT_W = $clog2(ROOT_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SQX, S_SQY, S_ITER, S_CHECK, S_MULV, S_MULA, S_MULB
  } state_t;

  state_t state;
  state_t state_pending;

  logic signed [DIFF_W-1:0] jdx;
  logic signed [DIFF_W-1:0] jdy;
  logic signed [ANG_W-1:0]  jheading;
  logic                     jcomp;

  logic [33:0]              d2;
  logic [19:0]              rem;
  logic [ROOT_STEPS-1:0]    root;
  logic [RCNT_W-1:0]        rcnt;

  logic signed [33:0]       cx;
  logic signed [33:0]       cy;
  logic signed [32:0]       cz;
  logic [STEP_W-1:0]        cstep;
  logic signed [ANG_W-1:0]  atq;

  logic signed [25:0]       vel_raw;
  logic signed [33:0]       sacc;
  logic                     out_valid;
  logic                     busy_done;

  logic signed [DIFF_W-1:0] dxa;
  logic signed [DIFF_W-1:0] dya;
  logic signed [33:0]       sq_x;
  logic signed [33:0]       sq_y;
  logic [19:0]              rem_sh;
  logic [19:0]              trial;
  logic                     root_run;
  logic                     cordic_run;
  logic signed [33:0]       xs;
  logic signed [33:0]       ys;
  logic signed [32:0]       tab_val;
  logic signed [32:0]       z_round;
  logic signed [ANG_W-1:0]  atq_cordic;
  logic signed [DIFF_W-1:0] alpha;
  logic signed [DIFF_W-1:0] beta;
  logic signed [33:0]       vprod;
  logic signed [33:0]       aprod;
  logic signed [33:0]       bprod;
  logic signed [33:0]       vsum;
  logic signed [26:0]       vel_f;
  logic signed [26:0]       stp_f;
  logic                     rev;
  logic                     out_free;

  function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
    logic signed [15:0] r;
    if (v > 27'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -27'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    dxa = jdx[DIFF_W-1] ? -jdx : jdx;
    dya = jdx[DIFF_W-1] ? -jdy : jdy;
    sq_x = jdx * jdx;
    sq_y = jdy * jdy;
    rem_sh = {rem[17:0], d2[33:32]};
    trial = {1'b0, root, 2'b01};
    root_run = (rcnt < RCNT_W'(ROOT_STEPS));
    cordic_run = (cstep < STEP_W'(CORDIC_STEPS));
    xs = cx >>> cstep;
    ys = cy >>> cstep;
    tab_val = $signed({1'b0, atan_entry(5'(cstep))});
    z_round = cz + 33'sd131072;
    atq_cordic = ANG_W'($signed(z_round[32:18]));
    alpha = DIFF_W'(atq) - DIFF_W'(jheading);
    beta = -DIFF_W'(atq);
    vprod = cfg.gain_dist * $signed({1'b0, root});
    aprod = cfg.gain_alpha * alpha;
    bprod = cfg.gain_beta * beta;
    vsum = vprod + 34'sd128;
    rev = jcomp && (jdx[DIFF_W-1] || jdy[DIFF_W-1]);
    vel_f = rev ? -27'(vel_raw) : 27'(vel_raw);
    stp_f = rev ? -27'($signed(sacc[33:8])) : 27'($signed(sacc[33:8]));
    out_free = !out_valid || pop;
    job_pop = (state == S_IDLE) && !busy_done && !q_empty;
  end

  assign empty = !out_valid;
  assign state_pending = state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy_done <= 1'b0;
      out_valid <= 1'b0;
      rcnt <= '0;
      cstep <= '0;
    end else begin
      if (busy_done && out_free) begin
        busy_done <= 1'b0;
        out_valid <= 1'b1;
        velocity <= sat16(vel_f);
        steering <= sat16(stp_f);
        computed <= jcomp;
        reversed <= rev;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state_pending)
        S_IDLE: begin
          if (job_pop) begin
            jdx <= job.dx;
            jdy <= job.dy;
            jheading <= job.heading;
            jcomp <= job.computed;
            state <= S_SQX;
          end
        end
        S_SQX: begin
          d2 <= 34'(sq_x);
          cx <= $signed({{3{dxa[DIFF_W-1]}}, dxa, 14'b0});
          cy <= $signed({{3{dya[DIFF_W-1]}}, dya, 14'b0});
          cz <= '0;
          cstep <= '0;
          vel_raw <= '0;
          sacc <= '0;
          if (jcomp) begin
            state <= S_SQY;
          end else begin
            busy_done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SQY: begin
          d2 <= d2 + 34'(sq_y);
          rem <= '0;
          root <= '0;
          rcnt <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (root_run) begin
            d2 <= {d2[31:0], 2'b00};
            rcnt <= rcnt + 1'b1;
            if (rem_sh >= trial) begin
              rem <= rem_sh - trial;
              root <= {root[ROOT_STEPS-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              root <= {root[ROOT_STEPS-2:0], 1'b0};
            end
          end
          if (cordic_run) begin
            cstep <= cstep + 1'b1;
            if (!cy[33]) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + tab_val;
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - tab_val;
            end
          end
          if (!root_run && !cordic_run) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ({1'b0, cfg.stop_tol} > root) begin
            busy_done <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (jdx == '0) begin
              if (jdy == '0) begin
                atq <= '0;
              end else if (jdy[DIFF_W-1]) begin
                atq <= -HALF_PI_Q12;
              end else begin
                atq <= HALF_PI_Q12;
              end
            end else begin
              atq <= atq_cordic;
            end
            state <= S_MULV;
          end
        end
        S_MULV: begin
          vel_raw <= vsum[33:8];
          state <= S_MULA;
        end
        S_MULA: begin
          sacc <= aprod + 34'sd128;
          state <= S_MULB;
        end
        S_MULB: begin
          sacc <= sacc + bprod;
          busy_done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/polar_pose_steering_controller_top.sv =====
// Top level of the polar pose steering controller: configuration registers and part wiring.
//
//   Channel   Handshake               Payload
//   input     push / full             op, pos_x, pos_y, heading
//   result    empty / pop             velocity, steering, computed, reversed
//   config    cfg_write               cfg_index, cfg_data
//
// Pose and target updates are registered in the front end. A tick becomes a job whose result
// passes the 17-step square root and the angle rotation, which share one iteration phase,
// then S_CHECK and S_MULV, S_MULA, S_MULB; inside the stop tolerance the multiply states are
// skipped, and a tick without both poses ends after S_SQX.
// Reset is synchronous and clears the flags, queues and configuration to defaults.
// A two-entry job queue and a one-entry result register let either side stall alone.
module polar_pose_steering_controller_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        op,
  input  logic signed [ppsc_pkg::POS_W-1:0] pos_x,
  input  logic signed [ppsc_pkg::POS_W-1:0] pos_y,
  input  logic signed [ppsc_pkg::ANG_W-1:0] heading,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [ppsc_pkg::POS_W-1:0] velocity,
  output logic signed [ppsc_pkg::ANG_W-1:0] steering,
  output logic                              computed,
  output logic                              reversed,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [ppsc_pkg::CFG_W-1:0]        cfg_data
);
  import ppsc_pkg::*;

  cfg_t cfg;
  job_t fr_job;
  job_t q_job;
  logic fr_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign full = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_tol <= STOP_TOL_RESET;
      cfg.gain_dist <= GAIN_DIST_RESET;
      cfg.gain_alpha <= GAIN_ALPHA_RESET;
      cfg.gain_beta <= GAIN_BETA_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STOP_TOL: cfg.stop_tol <= cfg_data;
        REG_GAIN_DIST: cfg.gain_dist <= $signed(cfg_data);
        REG_GAIN_ALPHA: cfg.gain_alpha <= $signed(cfg_data);
        REG_GAIN_BETA: cfg.gain_beta <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  ppsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (q_full),
    .op       (op),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .heading  (heading),
    .job_push (fr_push),
    .job      (fr_job)
  );

  ppsc_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fr_push),
    .wr_job  (fr_job),
    .rd_en   (q_pop),
    .rd_job  (q_job),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  ppsc_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .job      (q_job),
    .q_empty  (q_empty),
    .job_pop  (q_pop),
    .empty    (empty),
    .pop      (pop),
    .velocity (velocity),
    .steering (steering),
    .computed (computed),
    .reversed (reversed)
  );

endmodule
